FILE: sv/tkph_pkg.sv
// Shared types and constants of the touch key packet handler.
`timescale 1ns / 1ps
package tkph_pkg;

	// Item function codes
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_PKT  = 2'd1;
	localparam logic [1:0] FUNC_MAP  = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_KEY    = 2'd1;
	localparam logic [1:0] KIND_BUTTON = 2'd2;

	// Configuration register indexes
	localparam logic REG_SENS     = 1'b0;
	localparam logic REG_DEBOUNCE = 1'b1;

	// Controller packet patterns
	localparam logic [31:0] HELLO_A        = 32'h5555_5555;
	localparam logic [31:0] HELLO_B        = 32'h5655_5555;
	localparam logic [31:0] STATUS_ID      = 32'h5600_0001;
	localparam logic [31:0] STATUS_ID_MASK = 32'hFF00_0003;
	localparam logic [31:0] WRITE_ID       = 32'h5400_0001;
	localparam logic [31:0] SENS_REG       = 32'h0040_0000;
	localparam logic [31:0] SENS_FIELD     = 32'h000F_0000;
	localparam logic [31:0] BUTTON_FIELD   = 32'h000F_FFFC;
	localparam logic [4:0]  LAST_BUTTON    = 5'd17;
	localparam logic [2:0]  SENS_MAX       = 3'd6;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] rx_word;
		logic [4:0]  map_index;
		logic [9:0]  map_code;
		logic        map_used;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] tx_word;
		logic [9:0]  key_code;
		logic        key_pressed;
		logic [4:0]  button_number;
		logic        last_of_run;
	} result_t;

	// One command from front to back: a write packet, or a button report
	// with optional release and press events.
	typedef struct packed {
		logic       is_write;
		logic [2:0] sens;
		logic [4:0] button;
		logic       rel_vld;
		logic [9:0] rel_code;
		logic       prs_vld;
		logic [9:0] prs_code;
	} cmd_t;

endpackage

FILE: sv/touch_key_packet_handler_unit.sv
// Touch key packet handler: top level joining front end, command queue and back end.
//
// The block takes one item per cycle (tick, controller packet or key map write) as long
// as full is low; the front end updates bring-up, debounce and key map state at once and
// hands packets that need answering to a four-entry command queue. The back end drains
// that queue through an output register at one result per cycle while pop is high, so a
// status packet that yields a button report plus release and press events takes three
// results, a write packet one, and ticks, map writes and ignored packets none. The first
// result of an item passes through the command queue and then the output register before
// it can be popped. The key map resets to all entries unused; no clearing pass is needed.
`timescale 1ns / 1ps
module touch_key_packet_handler_unit import tkph_pkg::*; #(
	parameter int KEY_COUNT = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data
);

	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_nempty;
	logic cmd_pop;
	cmd_t cmd_head;

	assign accept = push && !full;

	tkph_front #(
		.KEY_COUNT(KEY_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	tkph_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.nempty (cmd_nempty),
		.rdata  (cmd_head)
	);

	tkph_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_nempty (cmd_nempty),
		.cmd        (cmd_head),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

FILE: sv/tkph_front.sv
// Front end: accepts items, keeps bring-up, debounce and key map state, issues commands.
`timescale 1ns / 1ps
module tkph_front import tkph_pkg::*; #(
	parameter int KEY_COUNT = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  item_t       item,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data,
	output logic        cmd_push,
	output cmd_t        cmd
);

	localparam int KIW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	typedef enum logic [2:0] {
		ST_WAIT   = 3'b001,
		ST_INIT   = 3'b010,
		ST_NORMAL = 3'b100
	} bringup_t;

	bringup_t    state_q;
	logic [2:0]  sens_q;
	logic [15:0] debounce_q;
	logic [15:0] since_q;
	logic        held_vld_q;
	logic [9:0]  held_code_q;
	logic        tab_vld_q [KEY_COUNT];
	logic [9:0]  tab_code_q [KEY_COUNT];

	logic        is_pkt;
	logic        is_status;
	logic        pass;
	logic [17:0] bits;
	logic        found;
	logic [4:0]  pos;
	logic [4:0]  key;
	logic        key_ok;
	logic        ent_vld;
	logic [9:0]  ent_code;
	logic        do_write;
	logic        do_buttons;
	logic        upd_held;
	logic        clr_held;

	assign is_pkt    = accept && (item.func == FUNC_PKT);
	assign is_status = (item.rx_word & STATUS_ID_MASK) == STATUS_ID;
	assign pass      = since_q > debounce_q;
	assign bits      = pass ? item.rx_word[19:2] : 18'd0;

	// Lowest set bit of the button field
	always_comb begin
		found = 1'b0;
		pos   = 5'd0;
		for (int i = 17; i >= 0; i--) begin
			if (bits[i]) begin
				found = 1'b1;
				pos   = 5'(i);
			end
		end
	end

	assign key    = LAST_BUTTON - pos;
	assign key_ok = found && (key < 5'(KEY_COUNT));

	always_comb begin
		ent_vld  = 1'b0;
		ent_code = '0;
		if (key_ok) begin
			ent_vld  = tab_vld_q[key[KIW-1:0]];
			ent_code = tab_code_q[key[KIW-1:0]];
		end
	end

	always_comb begin
		do_write   = 1'b0;
		do_buttons = 1'b0;
		case (state_q)
			ST_WAIT:   do_write   = is_pkt && ((item.rx_word == HELLO_A) ||
			                                   (item.rx_word == HELLO_B));
			ST_INIT:   do_write   = is_pkt;
			ST_NORMAL: do_buttons = is_pkt && is_status;
			default:   do_buttons = is_pkt && is_status;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.is_write = do_write;
		cmd.sens     = (sens_q > SENS_MAX) ? SENS_MAX : sens_q;
		cmd.button   = key_ok ? key + 5'd1 : 5'd0;
		upd_held     = 1'b0;
		clr_held     = 1'b0;
		if (ent_vld) begin
			if (!held_vld_q || (held_code_q != ent_code)) begin
				cmd.rel_vld  = held_vld_q;
				cmd.rel_code = held_code_q;
				cmd.prs_vld  = 1'b1;
				cmd.prs_code = ent_code;
				upd_held     = 1'b1;
			end
		end else if (!key_ok && held_vld_q) begin
			cmd.rel_vld  = 1'b1;
			cmd.rel_code = held_code_q;
			clr_held     = 1'b1;
		end
	end

	assign cmd_push = do_write || do_buttons;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_WAIT;
			sens_q     <= 3'd2;
			debounce_q <= 16'd20;
			since_q    <= '1;
			held_vld_q <= 1'b0;
			for (int i = 0; i < KEY_COUNT; i++) begin
				tab_vld_q[i] <= 1'b0;
			end
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_SENS:     sens_q     <= wr_data[2:0];
					REG_DEBOUNCE: debounce_q <= wr_data;
					default:      sens_q     <= sens_q;
				endcase
			end
			if (accept && (item.func == FUNC_TICK) && (since_q != '1)) begin
				since_q <= since_q + 16'd1;
			end
			if (accept && (item.func == FUNC_MAP) && (item.map_index < 5'(KEY_COUNT))) begin
				tab_vld_q[item.map_index[KIW-1:0]] <= item.map_used;
			end
			if (do_write) begin
				state_q <= ST_NORMAL;
			end
			if (do_buttons) begin
				if (pass) begin
					since_q <= '0;
				end
				if (upd_held) begin
					held_vld_q <= 1'b1;
				end else if (clr_held) begin
					held_vld_q <= 1'b0;
				end
			end
		end
	end

	// Payload: codes need no reset
	always_ff @(posedge clk) begin
		if (accept && (item.func == FUNC_MAP) && (item.map_index < 5'(KEY_COUNT))) begin
			tab_code_q[item.map_index[KIW-1:0]] <= item.map_code;
		end
		if (do_buttons && upd_held) begin
			held_code_q <= ent_code;
		end
	end

endmodule

FILE: sv/tkph_cmd_fifo.sv
// Short command queue between front and back.
`timescale 1ns / 1ps
module tkph_cmd_fifo import tkph_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic nempty,
	output cmd_t rdata
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full   = count_q == (AW + 1)'(DEPTH);
	assign nempty = count_q != '0;
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: sv/tkph_back.sv
// Back end: expands each command into one to three result items.
`timescale 1ns / 1ps
module tkph_back import tkph_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_nempty,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	typedef enum logic [2:0] {
		PH_HEAD  = 3'b001,
		PH_REL   = 3'b010,
		PH_PRESS = 3'b100
	} phase_t;

	phase_t  phase_q;
	phase_t  phase_d;
	logic    out_vld_q;
	result_t out_q;
	result_t res_d;
	logic    load;

	assign load  = cmd_nempty && (!out_vld_q || pop);
	assign empty = !out_vld_q;
	assign result = out_q;

	always_comb begin
		res_d   = '0;
		phase_d = phase_q;
		cmd_pop = 1'b0;
		case (phase_q)
			PH_HEAD: begin
				if (cmd.is_write) begin
					res_d.result_kind = KIND_TX;
					res_d.tx_word = WRITE_ID | SENS_REG |
					                ({13'd0, cmd.sens, 16'd0} & SENS_FIELD);
					res_d.last_of_run = 1'b1;
					cmd_pop = load;
				end else begin
					res_d.result_kind   = KIND_BUTTON;
					res_d.button_number = cmd.button;
					res_d.last_of_run   = !cmd.rel_vld && !cmd.prs_vld;
					cmd_pop = load && res_d.last_of_run;
					if (cmd.rel_vld) begin
						phase_d = PH_REL;
					end else if (cmd.prs_vld) begin
						phase_d = PH_PRESS;
					end
				end
			end
			PH_REL: begin
				res_d.result_kind = KIND_KEY;
				res_d.key_code    = cmd.rel_code;
				res_d.last_of_run = !cmd.prs_vld;
				cmd_pop = load && !cmd.prs_vld;
				phase_d = cmd.prs_vld ? PH_PRESS : PH_HEAD;
			end
			PH_PRESS: begin
				res_d.result_kind = KIND_KEY;
				res_d.key_code    = cmd.prs_code;
				res_d.key_pressed = 1'b1;
				res_d.last_of_run = 1'b1;
				cmd_pop = load;
				phase_d = PH_HEAD;
			end
			default: begin
				phase_d = PH_HEAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEAD;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q   <= phase_d;
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_d;
		end
	end

endmodule

FILE: tb/tb_top.sv
// Testbench of the touch key packet handler: directed table, then checked random traffic.
`timescale 1ns / 1ps
module tb_top;
	import tkph_pkg::*;

	localparam int KEYS          = 18;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT    = 4000;
	localparam int MAX_REPORTS   = 40;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam result_t    NO_RESULT = '0;

	typedef enum logic [1:0] {
		WAIT_HELLO = 2'd0,
		NEED_INIT  = 2'd1,
		RUNNING    = 2'd2
	} bringup_e;

	typedef struct {
		item_t   it;
		bit      typed;
		bit      has_res;
		result_t res;
	} dir_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        push     = 1'b0;
	logic        pop      = 1'b0;
	logic        wr_en    = 1'b0;
	logic        wr_index = REG_SENS;
	logic [15:0] wr_data  = '0;
	item_t       in_item  = '0;
	result_t     out_result;
	logic        full;
	logic        empty;

	// Predictor state, at its reset values
	bringup_e    phase        = WAIT_HELLO;
	logic [15:0] since_status = 16'hFFFF;
	logic        held_vld     = 1'b0;
	logic [9:0]  held_code    = '0;
	logic [4:0]  cur_button   = '0;
	bit          map_vld [KEYS];
	bit [9:0]    map_code_tbl [KEYS];
	logic [2:0]  sens_cfg     = 3'd2;
	logic [15:0] debounce_cfg = 16'd20;

	result_t  step_results[$];
	result_t  expected_results[$];
	dir_row_t rows[$];
	int       errors       = 0;
	int       results_seen = 0;
	int       idle_cycles  = 0;
	bit       steady       = 1'b0;
	bit       held_off     = 1'b0;

	touch_key_packet_handler_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (in_item),
		.empty    (empty),
		.pop      (pop),
		.result   (out_result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t make_result(logic [1:0] kind, logic [31:0] tx, logic [9:0] code,
			logic pressed, logic [4:0] button, logic last);
		result_t r;
		r.result_kind   = kind;
		r.tx_word       = tx;
		r.key_code      = code;
		r.key_pressed   = pressed;
		r.button_number = button;
		r.last_of_run   = last;
		return r;
	endfunction

	// Lowest set bit picks the key, numbered from the top down.
	function automatic void report_buttons(logic [17:0] bits);
		int         pos;
		int         key;
		logic       vld;
		logic [9:0] code;
		pos  = -1;
		vld  = 1'b0;
		code = '0;
		for (int i = 0; i < KEYS; i++)
			if (pos < 0 && bits[i]) pos = i;
		if (pos >= 0) begin
			key        = LAST_BUTTON - pos;
			cur_button = 5'(key + 1);
			vld        = map_vld[key];
			code       = map_code_tbl[key];
		end else begin
			cur_button = '0;
		end
		step_results.push_back(make_result(KIND_BUTTON, '0, '0, 1'b0, cur_button, 1'b0));
		if (vld) begin
			if (!held_vld || held_code != code) begin
				if (held_vld)
					step_results.push_back(make_result(KIND_KEY, '0, held_code, 1'b0, '0, 1'b0));
				step_results.push_back(make_result(KIND_KEY, '0, code, 1'b1, '0, 1'b0));
				held_vld  = 1'b1;
				held_code = code;
			end
		end else if (pos < 0 && held_vld) begin
			step_results.push_back(make_result(KIND_KEY, '0, held_code, 1'b0, '0, 1'b0));
			held_vld = 1'b0;
		end
	endfunction

	function automatic void predict_item(item_t it);
		logic [2:0] s;
		result_t    r;
		step_results.delete();
		case (it.func)
			FUNC_TICK: begin
				if (since_status != 16'hFFFF) since_status++;
			end
			FUNC_PKT: begin
				if ((phase == WAIT_HELLO && (it.rx_word == HELLO_A || it.rx_word == HELLO_B)) ||
						phase == NEED_INIT) begin
					s = (sens_cfg > SENS_MAX) ? SENS_MAX : sens_cfg;
					step_results.push_back(make_result(KIND_TX,
						WRITE_ID | SENS_REG | ((32'(s) << 16) & SENS_FIELD), '0, 1'b0, '0, 1'b0));
					phase = RUNNING;
				end else if (phase != WAIT_HELLO && (it.rx_word & STATUS_ID_MASK) == STATUS_ID) begin
					// inside the debounce window the packet reads as all keys released
					if (since_status > debounce_cfg) begin
						report_buttons(it.rx_word[19:2]);
						since_status = '0;
					end else begin
						report_buttons('0);
					end
				end
			end
			FUNC_MAP: begin
				if (it.map_index < KEYS) begin
					map_vld[it.map_index]      = it.map_used;
					map_code_tbl[it.map_index] = it.map_code;
				end
			end
			default: ;
		endcase
		if (step_results.size() != 0) begin
			r = step_results.pop_back();
			r.last_of_run = 1'b1;
			step_results.push_back(r);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic item_t pkt_item(logic [31:0] w);
		item_t it;
		it = '0;
		it.func = FUNC_PKT;
		it.rx_word = w;
		return it;
	endfunction

	function automatic item_t map_item(logic [4:0] idx, logic [9:0] code, logic used);
		item_t it;
		it = '0;
		it.func = FUNC_MAP;
		it.map_index = idx;
		it.map_code = code;
		it.map_used = used;
		return it;
	endfunction

	function automatic dir_row_t row(item_t it, bit typed, bit has_res, result_t res);
		dir_row_t d;
		d.it      = it;
		d.typed   = typed;
		d.has_res = has_res;
		d.res     = res;
		return d;
	endfunction

	function automatic item_t random_item(output bit noise);
		item_t it;
		int    r;
		it.func      = FUNC_TICK;
		it.rx_word   = $urandom;
		it.map_index = 5'($urandom);
		it.map_code  = 10'($urandom);
		it.map_used  = 1'($urandom);
		noise = 1'b0;
		r = $urandom_range(99);
		if (r < 44) begin
			it.func = FUNC_TICK;
		end else if (r < 74) begin
			it.func = FUNC_PKT;
			it.rx_word[31:24] = STATUS_ID[31:24];
			it.rx_word[1:0]   = STATUS_ID[1:0];
			case ($urandom_range(9))
				0, 1:    it.rx_word[19:2] = '0;
				2, 3, 4: it.rx_word[19:2] = 18'(1) << $urandom_range(17);
				default: ; // several keys at once, lowest wins
			endcase
		end else if (r < 87) begin
			it.func = FUNC_MAP;
			if ($urandom_range(7) != 0) it.map_index = 5'($urandom_range(17));
			it.map_used = ($urandom_range(4) != 0);
		end else if (r < 95) begin
			it.func = FUNC_PKT;
			noise = 1'b1;
			if ($urandom_range(3) == 0) it.rx_word = $urandom_range(1) ? HELLO_A : HELLO_B;
		end else begin
			it.func = FUNC_NONE;
			noise = 1'b1;
		end
		return it;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endfunction

	task automatic send_item(input item_t it, input bit typed, input bit has_res,
			input result_t res);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		predict_item(it);
		if (!typed) begin
			foreach (step_results[i]) expected_results.push_back(step_results[i]);
		end else if (has_res) begin
			expected_results.push_back(res);
		end
	endtask

	task automatic run_traffic(input int count);
		int    n;
		item_t it;
		bit    noise;
		n = 0;
		while (n < count) begin
			it = random_item(noise);
			send_item(it, 1'b0, 1'b0, NO_RESULT);
			if (!noise) n++;
		end
	endtask

	// Both registers, back to back; upper data bits above the sensitivity are junk.
	task automatic set_config(input logic [2:0] s, input logic [15:0] d);
		logic [12:0] junk;
		junk = 13'($urandom);
		wr_en    <= 1'b1;
		wr_index <= REG_SENS;
		wr_data  <= {junk, s};
		@(posedge clk);
		wr_index <= REG_DEBOUNCE;
		wr_data  <= d;
		@(posedge clk);
		wr_en <= 1'b0;
		sens_cfg     = s;
		debounce_cfg = d;
	endtask

	// Hold the input until every item has come out, then let in-flight work settle.
	task automatic drain();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		item_t odd;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(3'd7, 16'd0);

		odd = pkt_item(HELLO_A);
		odd.func = FUNC_NONE;
		odd.map_index = 5'd31;
		odd.map_code = 10'h3FF;
		odd.map_used = 1'b1;

		rows.push_back(row(pkt_item(32'h0000_0000), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5555_5554), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5600_0005), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row('0, 1'b1, 1'b0, NO_RESULT));
		// sensitivity 7 saturates to the top of the range
		rows.push_back(row(pkt_item(HELLO_B), 1'b1, 1'b1, make_result(KIND_TX,
			WRITE_ID | SENS_REG | (32'(SENS_MAX) << 16), '0, 1'b0, '0, 1'b1)));
		rows.push_back(row(pkt_item(HELLO_A), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5600_0001), 1'b1, 1'b1,
			make_result(KIND_BUTTON, '0, '0, 1'b0, '0, 1'b1)));
		rows.push_back(row(map_item(5'd17, 10'h3FF, 1'b1), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(map_item(5'd0, 10'h000, 1'b1), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(map_item(5'd31, 10'h155, 1'b1), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(map_item(5'd18, 10'h2AA, 1'b1), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row('0, 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5600_0005), 1'b0, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5600_0005), 1'b0, 1'b0, NO_RESULT));
		rows.push_back(row('0, 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5608_0001), 1'b0, 1'b0, NO_RESULT));
		rows.push_back(row('0, 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h560F_FFFD), 1'b0, 1'b0, NO_RESULT));
		rows.push_back(row(map_item(5'd5, 10'h2AA, 1'b0), 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row('0, 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5600_4001), 1'b0, 1'b0, NO_RESULT));
		rows.push_back(row('0, 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h56F0_0001), 1'b0, 1'b0, NO_RESULT));
		rows.push_back(row(odd, 1'b1, 1'b0, NO_RESULT));
		rows.push_back(row(pkt_item(32'h5600_0003), 1'b1, 1'b0, NO_RESULT));

		foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].has_res, rows[i].res);
		drain();

		set_config(3'd0, 16'd2);
		run_traffic(104);
		drain();
		set_config(3'd3, 16'hFFFF);
		run_traffic(35);
		drain();
		steady = 1'b1;
		set_config(3'd6, 16'd1);
		run_traffic(130);
		drain();
		steady = 1'b0;
		set_config(3'd5, 16'd0);
		run_traffic(112);
		drain();

		if (errors == 0 && expected_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Result side: random pop gaps, plus one long hold-off so the input backs up.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (!held_off && results_seen >= 40) begin
				held_off = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, got %h", $time, out_result);
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 32'(want.result_kind), 32'(out_result.result_kind));
				check_field("tx_word", want.tx_word, out_result.tx_word);
				check_field("key_code", 32'(want.key_code), 32'(out_result.key_code));
				check_field("key_pressed", 32'(want.key_pressed), 32'(out_result.key_pressed));
				check_field("button_number", 32'(want.button_number),
					32'(out_result.button_number));
				check_field("last_of_run", 32'(want.last_of_run), 32'(out_result.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

FILE: touch_key_packet_handler_unit.f
sv/tkph_pkg.sv
sv/tkph_front.sv
sv/tkph_cmd_fifo.sv
sv/tkph_back.sv
sv/touch_key_packet_handler_unit.sv
tb/tb_top.sv
